// ===== rtl/core/multi_slot_task_timer_defines.svh =====
// Assertion macros for the checker file of the timer table.
`ifndef MULTI_SLOT_TASK_TIMER_DEFINES_SVH
`define MULTI_SLOT_TASK_TIMER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define MSST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define MSST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/msst_pkg.sv =====
`default_nettype none

package msst_pkg;

  localparam int unsigned SLOTS_DEF   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned DATA_W      = 32;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_ALLOC    = 3'd1,
    OP_ARM_REP  = 3'd2,
    OP_ARM_ONCE = 3'd3,
    OP_START    = 3'd4,
    OP_STOP     = 3'd5,
    OP_QUERY    = 3'd6
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED  = 2'd0,
    KIND_ALLOC  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_START,
    ST_EVAL,
    ST_FLUSH
  } exec_state_e;

  // Input transaction payload
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] interval_ms;
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] now_ms;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot_res;
    logic [DATA_W-1:0] handle_res;
    logic              flag;
    logic              last;
  } out_t;

  // Classified command handed from front to back
  typedef struct packed {
    opcode_e           op;
    logic              in_range;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] interval;
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] now;
  } cmd_t;

  // Command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/msst_fifo.sv =====
`default_nettype none

module msst_fifo
  import msst_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire cmd_t      wdata_i,
  input  wire logic      pop_i,
  output cmd_t           rdata_o,
  output q_status_t      status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = store_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msst_front.sv =====
`default_nettype none

module msst_front
  import msst_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_t       in_i,
  input  wire q_status_t q_status_i,
  output logic           push_o,
  output cmd_t           cmd_o
);

  localparam int unsigned MAX_NUM = (SLOTS < 15) ? SLOTS : 15;
  localparam logic [SLOT_W-1:0] MAX_SLOT = SLOT_W'(MAX_NUM);

  logic front_v_q, front_v_d;
  cmd_t front_q;
  cmd_t cmd_new;
  logic accept, keep, in_range;

  assign in_stall_o = front_v_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = front_v_q && !q_status_i.full;
  assign cmd_o      = front_q;
  assign in_range   = (in_i.slot != '0) && (in_i.slot <= MAX_SLOT);

  // classify: drop undefined codes and slot commands aimed out of range
  always_comb begin
    cmd_new.op       = OP_TICK;
    cmd_new.in_range = in_range;
    cmd_new.slot     = in_i.slot;
    cmd_new.interval = in_i.interval_ms;
    cmd_new.handle   = in_i.handle;
    cmd_new.now      = in_i.now_ms;
    keep             = 1'b0;
    case (in_i.opcode)
      OP_TICK: begin
        cmd_new.op = OP_TICK;
        keep       = 1'b1;
      end
      OP_ALLOC: begin
        cmd_new.op = OP_ALLOC;
        keep       = 1'b1;
      end
      OP_QUERY: begin
        cmd_new.op = OP_QUERY;
        keep       = 1'b1;
      end
      OP_ARM_REP: begin
        cmd_new.op = OP_ARM_REP;
        keep       = in_range;
        // a repeating period is at least one
        if (in_i.interval_ms == '0) begin
          cmd_new.interval = DATA_W'(1);
        end
      end
      OP_ARM_ONCE: begin
        cmd_new.op = OP_ARM_ONCE;
        keep       = in_range;
      end
      OP_START: begin
        cmd_new.op = OP_START;
        keep       = in_range;
      end
      OP_STOP: begin
        cmd_new.op = OP_STOP;
        keep       = in_range;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // front holding register
  always_comb begin
    front_v_d = front_v_q;
    if (accept && keep) begin
      front_v_d = 1'b1;
    end else if (push_o) begin
      front_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
    end else begin
      front_v_q <= front_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      front_q <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msst_exec.sv =====
`default_nettype none

module msst_exec
  import msst_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire q_status_t q_status_i,
  input  wire cmd_t      q_head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_t           out_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef struct packed {
    logic [DATA_W-1:0] interval;
    logic [DATA_W-1:0] deadline;
    logic [DATA_W-1:0] handle;
  } slot_ent_t;

  exec_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [SLOTS-1:0] used_q, used_d;
  logic [SLOTS-1:0] active_q, active_d;
  logic [SLOTS-1:0] rep_q, rep_d;
  logic              pend_v_q, pend_v_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic [DATA_W-1:0] pend_handle_q, pend_handle_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  slot_ent_t        slot_mem_q [SLOTS];
  slot_ent_t        rdata_q;
  slot_ent_t        wdata;
  logic [IDX_W-1:0] rd_addr, waddr;
  logic             we;

  logic [IDX_W-1:0] cmd_idx, free_idx;
  logic             free_found, cmd_used, out_can_load;
  logic             fire, eval_hold, emit;
  logic [DATA_W-1:0] diff;
  out_t             emit_data;

  assign cmd_idx      = IDX_W'(cmd_q.slot - SLOT_W'(1));
  assign cmd_used     = cmd_q.in_range && used_q[cmd_idx];
  assign out_can_load = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // due check for the slot under scan; read data belongs to idx_q
  assign diff = cmd_q.now - rdata_q.deadline;
  assign fire = used_q[idx_q] && active_q[idx_q] && (rdata_q.handle != '0) && !diff[DATA_W-1];
  assign eval_hold = fire && pend_v_q && !out_can_load;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        case (cmd_q.op)
          OP_TICK: state_d = ST_EVAL;
          OP_ALLOC, OP_QUERY: begin
            if (out_can_load) begin
              state_d = ST_IDLE;
            end
          end
          OP_START: state_d = cmd_used ? ST_START : ST_IDLE;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_START: state_d = ST_IDLE;
      ST_EVAL: begin
        if (!eval_hold && (idx_q == LAST_IDX)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q || out_can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and table updates
  always_comb begin
    pop_o         = 1'b0;
    cmd_d         = cmd_q;
    idx_d         = idx_q;
    used_d        = used_q;
    active_d      = active_q;
    rep_d         = rep_q;
    pend_v_d      = pend_v_q;
    pend_slot_d   = pend_slot_q;
    pend_handle_d = pend_handle_q;
    we            = 1'b0;
    waddr         = cmd_idx;
    wdata         = rdata_q;
    emit          = 1'b0;
    emit_data     = '0;
    emit_data.kind = KIND_FIRED;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o    = 1'b1;
          cmd_d    = q_head_i;
          idx_d    = '0;
          pend_v_d = 1'b0;
        end
      end
      ST_DEC: begin
        case (cmd_q.op)
          OP_ALLOC: begin
            if (out_can_load) begin
              emit           = 1'b1;
              emit_data.kind = KIND_ALLOC;
              emit_data.last = 1'b1;
              if (free_found) begin
                emit_data.slot_res = SLOT_W'(free_idx) + SLOT_W'(1);
                used_d[free_idx]   = 1'b1;
                active_d[free_idx] = 1'b0;
                rep_d[free_idx]    = 1'b0;
                we                 = 1'b1;
                waddr              = free_idx;
                wdata              = '0;
              end
            end
          end
          OP_ARM_REP, OP_ARM_ONCE: begin
            if (cmd_used) begin
              we             = 1'b1;
              wdata.interval = cmd_q.interval;
              wdata.deadline = cmd_q.now + cmd_q.interval;
              wdata.handle   = cmd_q.handle;
              rep_d[cmd_idx] = (cmd_q.op == OP_ARM_REP);
            end
          end
          OP_STOP: begin
            if (cmd_used) begin
              active_d[cmd_idx] = 1'b0;
            end
          end
          OP_QUERY: begin
            if (out_can_load) begin
              emit               = 1'b1;
              emit_data.kind     = KIND_STATUS;
              emit_data.slot_res = cmd_q.slot;
              emit_data.flag     = cmd_used && active_q[cmd_idx];
              emit_data.last     = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_START: begin
        we                = 1'b1;
        wdata.deadline    = cmd_q.now + rdata_q.interval;
        active_d[cmd_idx] = 1'b1;
      end
      ST_EVAL: begin
        if (!eval_hold) begin
          if (fire) begin
            // the previous fired slot is now known not to be the last one
            if (pend_v_q) begin
              emit                 = 1'b1;
              emit_data.kind       = KIND_FIRED;
              emit_data.slot_res   = pend_slot_q;
              emit_data.handle_res = pend_handle_q;
            end
            pend_v_d      = 1'b1;
            pend_slot_d   = SLOT_W'(idx_q) + SLOT_W'(1);
            pend_handle_d = rdata_q.handle;
            if (rep_q[idx_q] && (rdata_q.interval != '0)) begin
              we             = 1'b1;
              waddr          = idx_q;
              wdata.deadline = cmd_q.now + rdata_q.interval;
            end else begin
              active_d[idx_q] = 1'b0;
            end
          end
          if (idx_q != LAST_IDX) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_v_q && out_can_load) begin
          emit                 = 1'b1;
          emit_data.kind       = KIND_FIRED;
          emit_data.slot_res   = pend_slot_q;
          emit_data.handle_res = pend_handle_q;
          emit_data.last       = 1'b1;
          pend_v_d             = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // scan reads run one slot ahead so each slot costs one cycle unless a stalled result holds up a fired slot
  assign rd_addr = (cmd_q.op == OP_TICK) ? idx_d : cmd_idx;

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      used_q      <= '0;
      active_q    <= '0;
      rep_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      used_q      <= used_d;
      active_q    <= active_d;
      rep_q       <= rep_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    pend_slot_q   <= pend_slot_d;
    pend_handle_q <= pend_handle_d;
    out_q         <= out_d;
  end

  // slot table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_mem_q[waddr] <= wdata;
    end
    rdata_q <= slot_mem_q[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/multi_slot_task_timer.sv =====
// Timer table with SLOTS slots numbered from 1. Commands (tick, allocate, arm, start, stop,
// query) enter through a one-entry front register that drops undefined codes and slot
// commands aimed outside 1..SLOTS, then wait in a short queue for the executor. The
// executor owns the slot table: used, active and repeating bits in flops, and interval,
// deadline and handle in a memory with one write port and one registered read port. A
// tick walks the table one slot per memory read, and the walk pauses while a stalled
// result register holds up a fired slot; fired slots come out in slot order, and the last
// one is held back until the walk ends so it can carry the last marker. The executor
// decodes each command in a decode state; start on a slot in use then updates it in a start
// state, and a tick scans in an evaluate state and sends its last fired slot in a flush
// state. A tick with nothing due, arm, start and stop return no result. Reset frees every slot.
`default_nettype none

module multi_slot_task_timer
  import msst_pkg::*;
#(
  parameter int unsigned SLOTS  = SLOTS_DEF,
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_o
);

  q_status_t q_status;
  cmd_t      push_cmd, head_cmd;
  logic      push, pop;

  msst_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  msst_fifo #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_cmd),
    .pop_i    (pop),
    .rdata_o  (head_cmd),
    .status_o (q_status)
  );

  msst_exec #(
    .SLOTS (SLOTS)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_head_i    (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/msst_checker.sv =====
`default_nettype none
`include "multi_slot_task_timer_defines.svh"

module msst_checker
  import msst_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_o
);

  logic out_held, answer_v, fired_v, fired_ok, alloc_v;

  // result side terms
  assign out_held = out_valid_o && out_stall_i;
  assign answer_v = out_valid_o && (out_o.kind != KIND_FIRED);
  assign fired_v  = out_valid_o && (out_o.kind == KIND_FIRED);
  assign fired_ok = (out_o.slot_res != '0) && (out_o.handle_res != '0) && !out_o.flag;
  assign alloc_v  = out_valid_o && (out_o.kind == KIND_ALLOC);

  // a stalled result transaction stays in place
  `MSST_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_o), "stalled result changed")

  // allocation and status answers are single results
  `MSST_ASSERT(a_answer_last, answer_v |-> out_o.last, "answer without last marker")

  // a fired slot names a real slot and a nonzero handle
  `MSST_ASSERT(a_fired_fields, fired_v |-> fired_ok, "bad fired result")

  // allocation answers carry no handle and no flag
  `MSST_NEVER(a_alloc_fields, alloc_v && (out_o.handle_res != '0 || out_o.flag), "bad allocation answer")

endmodule

bind multi_slot_task_timer msst_checker u_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import msst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEF = 3'd7;  // undefined code, must be dropped
  localparam int unsigned RAND_ITEMS  = 305;
  localparam int unsigned DRAIN_CYCLES = 40;

  // Directed stimulus row: typed-in answer only where it is obvious
  typedef struct packed {
    in_t  cmd;
    logic typed;
    out_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Shadow copy of the slot table
  bit          tt_used     [SLOTS_DEF];
  bit          tt_active   [SLOTS_DEF];
  bit          tt_repeat   [SLOTS_DEF];
  bit [31:0]   tt_interval [SLOTS_DEF];
  bit [31:0]   tt_deadline [SLOTS_DEF];
  bit [31:0]   tt_handle   [SLOTS_DEF];

  out_t        step_events[$];     // results of the last predicted transaction
  out_t        awaited_events[$];  // results still owed by the block
  dir_row_t    dir_rows[$];
  out_t        want_ev;
  int          err_count = 0;
  int          sent_items = 0;
  int          burst_left = 0;
  logic [31:0] ms_clock = '0;
  logic [7:0]  stall_phase = '0;

  multi_slot_task_timer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Slot number 1..SLOTS that is in use; idx is the table index
  function automatic bit slot_live(input logic [3:0] s, output int idx);
    idx = int'(s) - 1;
    return (s >= 1 && s <= SLOTS_DEF) && tt_used[idx];
  endfunction

  // Apply one command to the shadow table, leaving its results in step_events
  function automatic void timer_table_step(input in_t c);
    int          idx;
    bit          hit;
    logic [31:0] iv;
    logic [31:0] lag;
    out_t        r;
    hit = slot_live(c.slot, idx);
    r = '0;
    step_events.delete();
    case (c.opcode)
      OP_TICK: begin
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if (tt_used[i] && tt_active[i] && tt_handle[i] != 0) begin
            lag = c.now_ms - tt_deadline[i];
            if (!lag[31]) begin
              if (tt_repeat[i] && tt_interval[i] != 0)
                tt_deadline[i] = c.now_ms + tt_interval[i];
              else
                tt_active[i] = 1'b0;
              r.kind = KIND_FIRED;
              r.slot_res = 4'(i + 1);
              r.handle_res = tt_handle[i];
              step_events.push_back(r);
            end
          end
        end
      end
      OP_ALLOC: begin
        r.kind = KIND_ALLOC;
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if (!tt_used[i] && r.slot_res == 0) begin
            tt_used[i] = 1'b1;
            tt_active[i] = 1'b0;
            tt_repeat[i] = 1'b0;
            tt_interval[i] = '0;
            tt_deadline[i] = '0;
            tt_handle[i] = '0;
            r.slot_res = 4'(i + 1);
          end
        end
        step_events.push_back(r);
      end
      OP_ARM_REP, OP_ARM_ONCE: begin
        if (hit) begin
          iv = c.interval_ms;
          if (c.opcode == OP_ARM_REP && iv == 0) iv = 32'd1;
          tt_interval[idx] = iv;
          tt_handle[idx] = c.handle;
          tt_repeat[idx] = (c.opcode == OP_ARM_REP);
          tt_deadline[idx] = c.now_ms + iv;
        end
      end
      OP_START: begin
        if (hit) begin
          tt_active[idx] = 1'b1;
          tt_deadline[idx] = c.now_ms + tt_interval[idx];
        end
      end
      OP_STOP: begin
        if (hit) tt_active[idx] = 1'b0;
      end
      OP_QUERY: begin
        r.kind = KIND_STATUS;
        r.slot_res = c.slot;
        r.flag = hit && tt_active[idx];
        step_events.push_back(r);
      end
      default: ;
    endcase
    if (step_events.size() > 0) begin
      r = step_events.pop_back();
      r.last = 1'b1;
      step_events.push_back(r);
    end
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [3:0] s,
                                  input logic [31:0] iv, input logic [31:0] h,
                                  input logic [31:0] now, input logic typed,
                                  input logic [3:0] want_slot, input logic want_flag);
    dir_row_t row;
    row = '0;
    row.cmd.opcode = op;
    row.cmd.slot = s;
    row.cmd.interval_ms = iv;
    row.cmd.handle = h;
    row.cmd.now_ms = now;
    row.typed = typed;
    row.want.kind = (op == OP_ALLOC) ? KIND_ALLOC : KIND_STATUS;
    row.want.slot_res = want_slot;
    row.want.flag = want_flag;
    row.want.last = 1'b1;
    dir_rows.push_back(row);
  endfunction

  // Random command with mostly small intervals and the running time
  function automatic in_t timer_cmd(input logic [2:0] op, input logic [3:0] s);
    in_t         c;
    int unsigned pick;
    c.opcode = op;
    c.slot = s;
    pick = $urandom_range(0, 9);
    if (pick < 6) c.interval_ms = $urandom_range(0, 12);
    else if (pick < 8) c.interval_ms = $urandom_range(0, 300);
    else if (pick == 8) c.interval_ms = $urandom;
    else c.interval_ms = 32'h7FFF_FFF0 + $urandom_range(0, 31);
    c.handle = ($urandom_range(0, 6) == 0) ? 32'd0 : $urandom;
    c.now_ms = ($urandom_range(0, 19) == 0) ? $urandom : ms_clock;
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 20) $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  // Drive one transaction, predict on acceptance, then maybe pause the burst
  task automatic issue(input in_t c, input logic typed, input out_t want);
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    timer_table_step(c);
    if (typed) awaited_events.push_back(want);
    else foreach (step_events[i]) awaited_events.push_back(step_events[i]);
    sent_items++;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Result side stall pattern: calm, light, heavy and very heavy phases
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want_ev = awaited_events.pop_front();
        if (out_data.kind !== want_ev.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want_ev.kind));
        if (out_data.slot_res !== want_ev.slot_res)
          report_mismatch($sformatf("slot %0d, want %0d", out_data.slot_res, want_ev.slot_res));
        if (out_data.handle_res !== want_ev.handle_res)
          report_mismatch($sformatf("handle %h, want %h", out_data.handle_res,
                                    want_ev.handle_res));
        if (out_data.flag !== want_ev.flag)
          report_mismatch($sformatf("flag %b, want %b", out_data.flag, want_ev.flag));
        if (out_data.last !== want_ev.last)
          report_mismatch($sformatf("last %b, want %b", out_data.last, want_ev.last));
      end
    end
  end

  initial begin
    in_t         c;
    int unsigned pick;
    logic [3:0]  s;
    logic [2:0]  op;

    // Directed table
    add_row(OP_QUERY, 4'd1, '0, '0, '0, 1'b1, 4'd1, 1'b0);  // nothing in use after reset
    for (int k = 1; k <= SLOTS_DEF; k++)
      add_row(OP_ALLOC, '0, '0, '0, '0, 1'b1, 4'(k), 1'b0);
    add_row(OP_ALLOC, '0, '0, '0, '0, 1'b1, 4'd0, 1'b0);   // table full
    add_row(OP_ARM_REP, 4'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(OP_ARM_ONCE, 4'd2, 32'hFFFF_FFFF, 32'd1, 32'd0, 1'b0, '0, 1'b0);
    add_row(OP_ARM_ONCE, 4'd3, 32'd5, 32'd0, 32'd0, 1'b0, '0, 1'b0);  // null handle
    add_row(OP_ARM_REP, 4'd0, 32'd3, 32'd7, 32'd0, 1'b0, '0, 1'b0);   // bad slot
    add_row(OP_START, 4'd1, '0, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(OP_START, 4'd2, '0, '0, 32'd0, 1'b0, '0, 1'b0);
    add_row(OP_START, 4'd3, '0, '0, 32'd0, 1'b0, '0, 1'b0);
    add_row(OP_QUERY, 4'd1, '0, '0, '0, 1'b1, 4'd1, 1'b1);
    add_row(OP_QUERY, 4'd9, '0, '0, '0, 1'b1, 4'd9, 1'b0);  // out of range
    add_row(OP_TICK, '0, '0, '0, 32'd5, 1'b0, '0, 1'b0);
    add_row(OP_STOP, 4'd1, '0, '0, '0, 1'b0, '0, 1'b0);
    add_row(OP_QUERY, 4'd1, '0, '0, '0, 1'b1, 4'd1, 1'b0);
    add_row(OP_START, 4'd1, '0, '0, 32'd0, 1'b0, '0, 1'b0);
    add_row(OP_UNDEF, 4'd1, 32'd1, 32'd1, 32'd1, 1'b0, '0, 1'b0);
    // signed difference at and just below the half-range boundary
    add_row(OP_TICK, '0, '0, '0, 32'h8000_0001, 1'b0, '0, 1'b0);
    add_row(OP_TICK, '0, '0, '0, 32'h8000_0000, 1'b0, '0, 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) issue(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

    // Random part: mostly arm/start/tick sequences on live slots
    ms_clock = $urandom;
    while (sent_items < dir_rows.size() + RAND_ITEMS) begin
      pick = $urandom_range(0, 49);
      if (pick == 0) ms_clock = $urandom;
      else if (pick == 1) ms_clock += 32'h7FFF_FFFF + $urandom_range(0, 2);
      else ms_clock += $urandom_range(0, 6);

      s = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                      : 4'($urandom_range(1, SLOTS_DEF));
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // every slot due at once
        for (int k = 1; k <= SLOTS_DEF; k++) begin
          op = $urandom_range(0, 1) ? OP_ARM_REP : OP_ARM_ONCE;
          c = timer_cmd(op, 4'(k));
          c.interval_ms = $urandom_range(0, 3);
          c.handle = $urandom | 32'd1;
          c.now_ms = ms_clock;
          issue(c, 1'b0, '0);
        end
        for (int k = 1; k <= SLOTS_DEF; k++) begin
          c = timer_cmd(OP_START, 4'(k));
          c.now_ms = ms_clock;
          issue(c, 1'b0, '0);
        end
        ms_clock += 32'd4;
        issue(timer_cmd(OP_TICK, '0), 1'b0, '0);
      end else if (pick < 45) begin
        op = $urandom_range(0, 1) ? OP_ARM_REP : OP_ARM_ONCE;
        issue(timer_cmd(op, s), 1'b0, '0);
        issue(timer_cmd(OP_START, s), 1'b0, '0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) op = OP_TICK;
        else if (pick < 50) op = OP_ALLOC;
        else if (pick < 62) op = $urandom_range(0, 1) ? OP_ARM_REP : OP_ARM_ONCE;
        else if (pick < 74) op = OP_START;
        else if (pick < 84) op = OP_STOP;
        else if (pick < 97) op = OP_QUERY;
        else op = OP_UNDEF;
        issue(timer_cmd(op, s), 1'b0, '0);
      end
    end

    // Drain
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
